>>> design/scmk_pkg.sv
// ----------------------------------------------------------------------------
// scmk_pkg
// shared types, constants and the scancode position table
// ----------------------------------------------------------------------------
package scmk_pkg;

	// pressed list
	localparam int LIST_DEPTH = 16;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	// command queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] BREAK_PREFIX = 8'hF0;
	localparam logic [7:0] NO_BYTE      = 8'h00;
	localparam logic [7:0] COL_ONES     = 8'hFF;

	typedef enum logic [1:0] {
		CMD_QUERY   = 2'd0,
		CMD_PRESS   = 2'd1,
		CMD_RELEASE = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] code;   // scancode, or column mask for a query
		logic [2:0] col;
		logic [2:0] row;
	} cmd_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] col;
		logic [2:0] row;
	} key_pos_t;

	function automatic key_pos_t key_lookup(input logic [7:0] code);
		key_pos_t p;
		p.hit = 1'b1;
		p.col = 3'd0;
		p.row = 3'd0;
		unique case (code)
			8'h16: begin p.col = 3'd7; p.row = 3'd0; end
			8'h1E: begin p.col = 3'd7; p.row = 3'd3; end
			8'h26: begin p.col = 3'd1; p.row = 3'd0; end
			8'h25: begin p.col = 3'd1; p.row = 3'd3; end
			8'h2E: begin p.col = 3'd2; p.row = 3'd0; end
			8'h36: begin p.col = 3'd2; p.row = 3'd3; end
			8'h3D: begin p.col = 3'd3; p.row = 3'd0; end
			8'h3E: begin p.col = 3'd3; p.row = 3'd3; end
			8'h46: begin p.col = 3'd4; p.row = 3'd0; end
			8'h45: begin p.col = 3'd4; p.row = 3'd3; end
			8'h15: begin p.col = 3'd7; p.row = 3'd6; end
			8'h1D: begin p.col = 3'd1; p.row = 3'd1; end
			8'h24: begin p.col = 3'd1; p.row = 3'd6; end
			8'h2D: begin p.col = 3'd2; p.row = 3'd1; end
			8'h2C: begin p.col = 3'd2; p.row = 3'd6; end
			8'h35: begin p.col = 3'd3; p.row = 3'd1; end
			8'h3C: begin p.col = 3'd3; p.row = 3'd6; end
			8'h43: begin p.col = 3'd4; p.row = 3'd1; end
			8'h44: begin p.col = 3'd4; p.row = 3'd6; end
			8'h4D: begin p.col = 3'd5; p.row = 3'd1; end
			8'h1C: begin p.col = 3'd1; p.row = 3'd2; end
			8'h1B: begin p.col = 3'd1; p.row = 3'd5; end
			8'h23: begin p.col = 3'd2; p.row = 3'd2; end
			8'h2B: begin p.col = 3'd2; p.row = 3'd5; end
			8'h34: begin p.col = 3'd3; p.row = 3'd2; end
			8'h33: begin p.col = 3'd3; p.row = 3'd5; end
			8'h3B: begin p.col = 3'd4; p.row = 3'd2; end
			8'h42: begin p.col = 3'd4; p.row = 3'd5; end
			8'h4B: begin p.col = 3'd5; p.row = 3'd2; end
			8'h1A: begin p.col = 3'd1; p.row = 3'd4; end
			8'h22: begin p.col = 3'd2; p.row = 3'd7; end
			8'h21: begin p.col = 3'd2; p.row = 3'd4; end
			8'h2A: begin p.col = 3'd3; p.row = 3'd7; end
			8'h32: begin p.col = 3'd3; p.row = 3'd4; end
			8'h31: begin p.col = 3'd4; p.row = 3'd7; end
			8'h3A: begin p.col = 3'd4; p.row = 3'd4; end
			8'h29: begin p.col = 3'd7; p.row = 3'd4; end
			8'h41: begin p.col = 3'd5; p.row = 3'd7; end
			8'h49: begin p.col = 3'd5; p.row = 3'd4; end
			8'h4C: begin p.col = 3'd6; p.row = 3'd2; end
			8'h4E: begin p.col = 3'd5; p.row = 3'd3; end
			8'h55: begin p.col = 3'd5; p.row = 3'd0; end
			8'h54: begin p.col = 3'd5; p.row = 3'd6; end
			8'h5B: begin p.col = 3'd6; p.row = 3'd1; end
			8'h5D: begin p.col = 3'd6; p.row = 3'd0; end
			8'h52: begin p.col = 3'd7; p.row = 3'd3; end
			8'h61: begin p.col = 3'd6; p.row = 3'd7; end
			8'h5A: begin p.col = 3'd0; p.row = 3'd1; end
			8'h66: begin p.col = 3'd0; p.row = 3'd0; end
			8'h76: begin p.col = 3'd7; p.row = 3'd7; end
			8'h12: begin p.col = 3'd1; p.row = 3'd7; end
			8'h59: begin p.col = 3'd6; p.row = 3'd4; end
			8'h05: begin p.col = 3'd0; p.row = 3'd4; end
			8'h06: begin p.col = 3'd0; p.row = 3'd4; end
			8'h04: begin p.col = 3'd0; p.row = 3'd5; end
			8'h0C: begin p.col = 3'd0; p.row = 3'd5; end
			8'h03: begin p.col = 3'd0; p.row = 3'd6; end
			8'h0B: begin p.col = 3'd0; p.row = 3'd6; end
			8'h83: begin p.col = 3'd0; p.row = 3'd3; end
			8'h0A: begin p.col = 3'd0; p.row = 3'd3; end
			8'h75: begin p.col = 3'd0; p.row = 3'd7; end
			8'h72: begin p.col = 3'd0; p.row = 3'd7; end
			8'h6B: begin p.col = 3'd0; p.row = 3'd2; end
			8'h74: begin p.col = 3'd0; p.row = 3'd2; end
			default: p.hit = 1'b0;
		endcase
		return p;
	endfunction

endpackage

>>> design/scmk_front.sv
// ----------------------------------------------------------------------------
// scmk_front
// takes requests, tracks the break prefix and turns bytes into commands
// ----------------------------------------------------------------------------
module scmk_front import scmk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       enable_we,
	input  logic       enable_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [7:0] data_byte,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic     enable_q;
	logic     release_pending_q;
	logic     accept;
	logic     is_scan;
	key_pos_t pos;

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;
	assign pos      = key_lookup(data_byte);
	// a scancode that is acted on at all
	assign is_scan  = ~func & enable_q & (data_byte != NO_BYTE);

	always_comb begin
		push_cmd.op   = CMD_QUERY;
		push_cmd.code = data_byte;
		push_cmd.col  = pos.col;
		push_cmd.row  = pos.row;
		push          = 1'b0;
		if (func) begin
			push = accept;
		end else if (is_scan && data_byte != BREAK_PREFIX && pos.hit) begin
			// unmapped codes never reach the list, so drop them here
			push_cmd.op = release_pending_q ? CMD_RELEASE : CMD_PRESS;
			push        = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q          <= 1'b1;
			release_pending_q <= 1'b0;
		end else begin
			if (enable_we) begin
				enable_q <= enable_wdata;
			end
			if (accept && is_scan) begin
				release_pending_q <= (data_byte == BREAK_PREFIX);
			end
		end
	end

endmodule

>>> design/scmk_queue.sv
// ----------------------------------------------------------------------------
// scmk_queue
// small command fifo between front and back
// ----------------------------------------------------------------------------
module scmk_queue import scmk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t              slot_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> design/scmk_back.sv
// ----------------------------------------------------------------------------
// scmk_back
// held list, key matrix, rebuild sequencer and scan result register
// ----------------------------------------------------------------------------
module scmk_back import scmk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head_cmd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] row_data
);

	typedef struct packed {
		logic [7:0] code;
		logic [2:0] col;
		logic [2:0] row;
	} held_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'b01,
		ST_REBUILD = 2'b10
	} back_state_t;

	held_t             held_q [LIST_DEPTH];
	logic [CNT_W-1:0]  held_count_q;
	logic [7:0]        matrix_q [8];
	back_state_t       state_q;
	logic [CNT_W-1:0]  rb_idx_q;
	logic              out_valid_q;
	logic [7:0]        row_data_q;

	logic [LIST_DEPTH-1:0] match;
	logic                  found;
	logic [IDX_W-1:0]      found_idx;
	logic                  can_out;
	logic                  do_query;
	logic                  do_press;
	logic                  do_release;
	logic [7:0]            scan_acc;
	held_t                 rb_entry;

	assign can_out = ~out_valid_q | ~out_stall;
	assign pop     = head_valid && (state_q == ST_IDLE)
		&& ((head_cmd.op != CMD_QUERY) || can_out);

	assign do_query   = pop && (head_cmd.op == CMD_QUERY);
	assign do_press   = pop && (head_cmd.op == CMD_PRESS);
	assign do_release = pop && (head_cmd.op == CMD_RELEASE);

	// parallel search, a code is held at most once
	always_comb begin
		found_idx = '0;
		for (int j = 0; j < LIST_DEPTH; j++) begin
			match[j] = (CNT_W'(j) < held_count_q) && (held_q[j].code == head_cmd.code);
			if (match[j]) begin
				found_idx = found_idx | IDX_W'(j);
			end
		end
		found = |match;
	end

	always_comb begin
		scan_acc = COL_ONES;
		for (int c = 0; c < 8; c++) begin
			if (head_cmd.code[c]) begin
				scan_acc = scan_acc & matrix_q[c];
			end
		end
	end

	assign rb_entry = held_q[rb_idx_q[IDX_W-1:0]];

	// list storage, no reset
	always_ff @(posedge clk) begin
		if (do_press && !found && held_count_q < CNT_W'(LIST_DEPTH)) begin
			for (int j = 0; j < LIST_DEPTH; j++) begin
				if (CNT_W'(j) == held_count_q) begin
					held_q[j] <= '{code: head_cmd.code, col: head_cmd.col,
						row: head_cmd.row};
				end
			end
		end else if (do_release && found) begin
			// close the gap, keeping the order
			for (int j = 0; j < LIST_DEPTH - 1; j++) begin
				if (IDX_W'(j) >= found_idx) begin
					held_q[j] <= held_q[j+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_query) begin
			row_data_q <= scan_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			state_q      <= ST_IDLE;
			rb_idx_q     <= '0;
			out_valid_q  <= 1'b0;
			for (int c = 0; c < 8; c++) begin
				matrix_q[c] <= COL_ONES;
			end
		end else begin
			if (do_query) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (do_press && !found) begin
						if (held_count_q < CNT_W'(LIST_DEPTH)) begin
							held_count_q <= held_count_q + 1'b1;
						end
						matrix_q[head_cmd.col][head_cmd.row] <= 1'b0;
					end else if (do_release && found) begin
						held_count_q <= held_count_q - 1'b1;
						rb_idx_q     <= '0;
						state_q      <= ST_REBUILD;
						for (int c = 0; c < 8; c++) begin
							matrix_q[c] <= COL_ONES;
						end
					end
				end
				ST_REBUILD: begin
					if (rb_idx_q < held_count_q) begin
						matrix_q[rb_entry.col][rb_entry.row] <= 1'b0;
						rb_idx_q <= rb_idx_q + 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign row_data  = row_data_q;

endmodule

>>> design/scancode_to_key_matrix_unit.sv
// ----------------------------------------------------------------------------
// scancode_to_key_matrix_unit
// ps/2 set-2 scancode bytes to an 8x8 active-low key matrix with scan queries
// ----------------------------------------------------------------------------
// a request with func low carries a scancode byte, with func high a column
// mask; only a scan query gives a result, row_data, the and of the selected
// columns (a clear bit is a pressed key, an empty mask gives all ones). the
// front takes one request a cycle while the four-entry command queue has
// room; bytes of zero, unmapped codes and scancodes while enable is low are
// dropped there, and the break prefix arms the next byte as a release. the
// back handles a press or a query when idle; a release of a held key
// resets the matrix and then walks the held list one entry a cycle, and
// takes no new command until the walk ends (the list holds at most 16
// entries). a query waits in the back until the result register is free.
// enable is written through enable_we / enable_wdata and resets to 1.
// ----------------------------------------------------------------------------
module scancode_to_key_matrix_unit import scmk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       enable_we,
	input  logic       enable_wdata,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [7:0] data_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] row_data
);

	// front to queue
	logic push;
	cmd_t push_cmd;
	logic q_full;

	// queue to back
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	// classification of bytes and the break prefix state
	scmk_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.enable_we    (enable_we),
		.enable_wdata (enable_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.data_byte    (data_byte),
		.q_full       (q_full),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	// decouples the front from a back that is busy rebuilding
	scmk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// held list, matrix and result register
	scmk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_data   (row_data)
	);

endmodule
